FILE: design/lpd_pkg.sv
// ----------------------------------------------------------------------------
// Leave point detector package
// Shared widths, register indexes, payload structs and sequencer codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lpd_pkg;

  localparam int CoordW   = 16;
  localparam int FracBits = 8;
  localparam int DistW    = 16;
  localparam int CfgW     = (CoordW > DistW) ? CoordW : DistW;
  localparam int CfgIdxW  = 3;
  localparam int DiffW    = CoordW + 1;

  localparam int TolResetInt = (1 << FracBits) / 2;
  localparam int MinResetInt = 2 << FracBits;
  localparam logic [DistW-1:0] TolReset = DistW'(TolResetInt);
  localparam logic [DistW-1:0] MinReset = DistW'(MinResetInt);

  typedef enum logic [CfgIdxW-1:0] {
    RegStartX,
    RegStartY,
    RegGoalX,
    RegGoalY,
    RegTolerance,
    RegMinLeave
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] robot_x;
    logic signed [CoordW-1:0] robot_y;
    logic signed [CoordW-1:0] hit_x;
    logic signed [CoordW-1:0] hit_y;
  } item_t;

  typedef struct packed {
    logic on_line;
    logic nearer_goal;
    logic far_from_hit;
    logic leave_found;
  } result_t;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] goal_x;
    logic signed [CoordW-1:0] goal_y;
    logic [DistW-1:0]         tolerance;
    logic [DistW-1:0]         min_leave;
  } cfg_t;

  typedef struct packed {
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [DiffW-1:0] ux;
    logic signed [DiffW-1:0] uy;
    logic signed [DiffW-1:0] rgx;
    logic signed [DiffW-1:0] rgy;
    logic signed [DiffW-1:0] hgx;
    logic signed [DiffW-1:0] hgy;
    logic signed [DiffW-1:0] rhx;
    logic signed [DiffW-1:0] rhy;
    logic                    between;
  } work_t;

  typedef enum logic [4:0] {
    StTol,
    StLenX,
    StLenY,
    StCrossA,
    StCrossB,
    StFarX,
    StFarY,
    StFarMin,
    StNearHx,
    StNearHy,
    StNearRx,
    StNearRy,
    StLineA,
    StLineB,
    StLineC,
    StLineD,
    StLineE,
    StLineF,
    StLineG,
    StDrain
  } step_e;

  typedef enum logic [2:0] {
    ShNone,
    ShHalf,
    ShHalfDbl,
    ShTolHi,
    ShTolHiHalf,
    ShFull
  } acc_shift_e;

  typedef enum logic [2:0] {
    DstNone,
    DstTol,
    DstLen,
    DstCross,
    DstFar,
    DstNear,
    DstLine
  } acc_dest_e;

  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    logic       sub;
    acc_shift_e shift;
    acc_dest_e  dest;
  } acc_op_t;

endpackage

`default_nettype wire

FILE: design/lpd_cfg.sv
// ----------------------------------------------------------------------------
// Leave point detector configuration registers
// Holds start, goal, line tolerance and minimum leave distance.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_cfg import lpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegStartX:    cfg_d.start_x   = cfg_data_i[CoordW-1:0];
        RegStartY:    cfg_d.start_y   = cfg_data_i[CoordW-1:0];
        RegGoalX:     cfg_d.goal_x    = cfg_data_i[CoordW-1:0];
        RegGoalY:     cfg_d.goal_y    = cfg_data_i[CoordW-1:0];
        RegTolerance: cfg_d.tolerance = cfg_data_i[DistW-1:0];
        RegMinLeave:  cfg_d.min_leave = cfg_data_i[DistW-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_x   <= '0;
      cfg_q.start_y   <= '0;
      cfg_q.goal_x    <= '0;
      cfg_q.goal_y    <= '0;
      cfg_q.tolerance <= TolReset;
      cfg_q.min_leave <= MinReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: design/lpd_front.sv
// ----------------------------------------------------------------------------
// Leave point detector front end
// Accepts positions, forms coordinate differences and the between test.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_front import lpd_pkg::*; (
  input  logic  push,
  output logic  full,
  input  item_t in_item_i,
  input  cfg_t  cfg_i,
  input  logic  fifo_full_i,
  output logic  fifo_push_o,
  output work_t fifo_data_o
);

  logic signed [CoordW-1:0] rx;
  logic signed [CoordW-1:0] ry;
  logic signed [CoordW-1:0] hx;
  logic signed [CoordW-1:0] hy;
  logic signed [CoordW-1:0] sx;
  logic signed [CoordW-1:0] sy;
  logic signed [CoordW-1:0] gx;
  logic signed [CoordW-1:0] gy;

  assign rx = in_item_i.robot_x;
  assign ry = in_item_i.robot_y;
  assign hx = in_item_i.hit_x;
  assign hy = in_item_i.hit_y;
  assign sx = cfg_i.start_x;
  assign sy = cfg_i.start_y;
  assign gx = cfg_i.goal_x;
  assign gy = cfg_i.goal_y;

  always_comb begin
    fifo_data_o.dx  = DiffW'(gx) - DiffW'(sx);
    fifo_data_o.dy  = DiffW'(gy) - DiffW'(sy);
    fifo_data_o.ux  = DiffW'(rx) - DiffW'(sx);
    fifo_data_o.uy  = DiffW'(ry) - DiffW'(sy);
    fifo_data_o.rgx = DiffW'(rx) - DiffW'(gx);
    fifo_data_o.rgy = DiffW'(ry) - DiffW'(gy);
    fifo_data_o.hgx = DiffW'(hx) - DiffW'(gx);
    fifo_data_o.hgy = DiffW'(hy) - DiffW'(gy);
    fifo_data_o.rhx = DiffW'(rx) - DiffW'(hx);
    fifo_data_o.rhy = DiffW'(ry) - DiffW'(hy);
    if (sx < gx) begin
      fifo_data_o.between = (rx > sx) && (rx < gx);
    end else if (sx > gx) begin
      fifo_data_o.between = (rx < sx) && (rx > gx);
    end else if (sy < gy) begin
      fifo_data_o.between = (ry > sy) && (ry < gy);
    end else begin
      fifo_data_o.between = (ry < sy) && (ry > gy);
    end
  end

  assign full        = fifo_full_i;
  assign fifo_push_o = push && !fifo_full_i;

endmodule

`default_nettype wire

FILE: design/lpd_fifo.sv
// ----------------------------------------------------------------------------
// Leave point detector work queue
// Two-entry queue between the front end and the arithmetic sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_fifo import lpd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output work_t data_o
);

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);

  work_t             mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q;
  logic [PtrW-1:0]   rd_ptr_q;
  logic [PtrW:0]     count_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (count_q == (PtrW + 1)'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/lpd_back.sv
// ----------------------------------------------------------------------------
// Leave point detector back end
// Sequencer around one shared multiplier and a signed accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_back import lpd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    fifo_valid_i,
  input  work_t   fifo_data_i,
  output logic    fifo_pop_o,
  output logic    res_valid_o,
  output result_t res_o,
  input  logic    res_pop_i
);

  localparam int HalfW  = DiffW;
  localparam int ProdW  = 2 * CoordW + 1;
  localparam int TolSqW = 2 * DistW;
  localparam int MulW   = (CoordW + 2 > DistW + 1) ? CoordW + 2 : DistW + 1;
  localparam int MulPW  = 2 * MulW;
  localparam int C2W    = 4 * CoordW + 2;
  localparam int RhsW   = 2 * CoordW + 1 + TolSqW;
  localparam int AccW   = ((C2W > RhsW) ? C2W : RhsW) + 2;

  step_e                    step_q;
  step_e                    step_d;
  logic                     busy_q;
  logic                     adv;
  logic                     done;
  logic                     start;
  work_t                    job_q;
  acc_op_t                  op_q;
  acc_op_t                  op_d;
  logic signed [MulW-1:0]   mul_a;
  logic signed [MulW-1:0]   mul_b;
  logic signed [MulPW-1:0]  prod_d;
  logic signed [MulPW-1:0]  prod_q;
  logic signed [AccW-1:0]   term;
  logic signed [AccW-1:0]   shifted;
  logic signed [AccW-1:0]   base;
  logic signed [AccW-1:0]   acc_d;
  logic signed [AccW-1:0]   acc_q;
  logic                     acc_pos;
  logic                     capture;
  logic [TolSqW-1:0]        tol2_q;
  logic [ProdW-1:0]         len2_q;
  logic signed [ProdW:0]    cross_raw_q;
  logic [ProdW-1:0]         cross_q;
  logic                     far_q;
  logic                     near_q;
  logic                     found_q;
  logic                     res_valid_q;
  result_t                  res_q;
  result_t                  res_d;

  function automatic acc_op_t mk_op(logic first, logic last, logic sub,
                                    acc_shift_e shift, acc_dest_e dest);
    acc_op_t op;
    op.valid = 1'b1;
    op.first = first;
    op.last  = last;
    op.sub   = sub;
    op.shift = shift;
    op.dest  = dest;
    return op;
  endfunction

  assign adv   = busy_q && !((step_q == StDrain) && res_valid_q && !res_pop_i);
  assign done  = adv && (step_q == StDrain);
  assign start = fifo_valid_i && (!busy_q || done);
  assign fifo_pop_o = start;

  always_comb begin
    step_d = step_q;
    if (start) begin
      step_d = StTol;
    end else if (adv && (step_q != StDrain)) begin
      step_d = step_e'(step_q + 5'd1);
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    op_d  = '0;
    unique case (step_q)
      StTol: begin
        mul_a = MulW'(cfg_i.tolerance);
        mul_b = MulW'(cfg_i.tolerance);
        op_d  = mk_op(1'b1, 1'b1, 1'b0, ShNone, DstTol);
      end
      StLenX: begin
        mul_a = MulW'(job_q.dx);
        mul_b = MulW'(job_q.dx);
        op_d  = mk_op(1'b1, 1'b0, 1'b0, ShNone, DstLen);
      end
      StLenY: begin
        mul_a = MulW'(job_q.dy);
        mul_b = MulW'(job_q.dy);
        op_d  = mk_op(1'b0, 1'b1, 1'b0, ShNone, DstLen);
      end
      StCrossA: begin
        mul_a = MulW'(job_q.dy);
        mul_b = MulW'(job_q.ux);
        op_d  = mk_op(1'b1, 1'b0, 1'b0, ShNone, DstCross);
      end
      StCrossB: begin
        mul_a = MulW'(job_q.dx);
        mul_b = MulW'(job_q.uy);
        op_d  = mk_op(1'b0, 1'b1, 1'b1, ShNone, DstCross);
      end
      StFarX: begin
        mul_a = MulW'(job_q.rhx);
        mul_b = MulW'(job_q.rhx);
        op_d  = mk_op(1'b1, 1'b0, 1'b0, ShNone, DstFar);
      end
      StFarY: begin
        mul_a = MulW'(job_q.rhy);
        mul_b = MulW'(job_q.rhy);
        op_d  = mk_op(1'b0, 1'b0, 1'b0, ShNone, DstFar);
      end
      StFarMin: begin
        mul_a = MulW'(cfg_i.min_leave);
        mul_b = MulW'(cfg_i.min_leave);
        op_d  = mk_op(1'b0, 1'b1, 1'b1, ShNone, DstFar);
      end
      StNearHx: begin
        mul_a = MulW'(job_q.hgx);
        mul_b = MulW'(job_q.hgx);
        op_d  = mk_op(1'b1, 1'b0, 1'b0, ShNone, DstNear);
      end
      StNearHy: begin
        mul_a = MulW'(job_q.hgy);
        mul_b = MulW'(job_q.hgy);
        op_d  = mk_op(1'b0, 1'b0, 1'b0, ShNone, DstNear);
      end
      StNearRx: begin
        mul_a = MulW'(job_q.rgx);
        mul_b = MulW'(job_q.rgx);
        op_d  = mk_op(1'b0, 1'b0, 1'b1, ShNone, DstNear);
      end
      StNearRy: begin
        mul_a = MulW'(job_q.rgy);
        mul_b = MulW'(job_q.rgy);
        op_d  = mk_op(1'b0, 1'b1, 1'b1, ShNone, DstNear);
      end
      StLineA: begin
        mul_a = MulW'(tol2_q[DistW-1:0]);
        mul_b = MulW'(len2_q[HalfW-1:0]);
        op_d  = mk_op(1'b1, 1'b0, 1'b0, ShNone, DstLine);
      end
      StLineB: begin
        mul_a = MulW'(tol2_q[DistW-1:0]);
        mul_b = MulW'(len2_q[ProdW-1:HalfW]);
        op_d  = mk_op(1'b0, 1'b0, 1'b0, ShHalf, DstLine);
      end
      StLineC: begin
        mul_a = MulW'(tol2_q[TolSqW-1:DistW]);
        mul_b = MulW'(len2_q[HalfW-1:0]);
        op_d  = mk_op(1'b0, 1'b0, 1'b0, ShTolHi, DstLine);
      end
      StLineD: begin
        mul_a = MulW'(tol2_q[TolSqW-1:DistW]);
        mul_b = MulW'(len2_q[ProdW-1:HalfW]);
        op_d  = mk_op(1'b0, 1'b0, 1'b0, ShTolHiHalf, DstLine);
      end
      StLineE: begin
        mul_a = MulW'(cross_q[HalfW-1:0]);
        mul_b = MulW'(cross_q[HalfW-1:0]);
        op_d  = mk_op(1'b0, 1'b0, 1'b1, ShNone, DstLine);
      end
      StLineF: begin
        mul_a = MulW'(cross_q[HalfW-1:0]);
        mul_b = MulW'(cross_q[ProdW-1:HalfW]);
        op_d  = mk_op(1'b0, 1'b0, 1'b1, ShHalfDbl, DstLine);
      end
      StLineG: begin
        mul_a = MulW'(cross_q[ProdW-1:HalfW]);
        mul_b = MulW'(cross_q[ProdW-1:HalfW]);
        op_d  = mk_op(1'b0, 1'b1, 1'b1, ShFull, DstLine);
      end
      StDrain: begin
        op_d = '0;
      end
      default: begin
        op_d = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;
  assign term   = AccW'(prod_q);

  always_comb begin
    unique case (op_q.shift)
      ShNone:      shifted = term;
      ShHalf:      shifted = term <<< HalfW;
      ShHalfDbl:   shifted = term <<< (HalfW + 1);
      ShTolHi:     shifted = term <<< DistW;
      ShTolHiHalf: shifted = term <<< (DistW + HalfW);
      ShFull:      shifted = term <<< (2 * HalfW);
      default:     shifted = term;
    endcase
  end

  always_comb begin
    base = op_q.first ? '0 : acc_q;
    if (!op_q.valid) begin
      acc_d = acc_q;
    end else if (op_q.sub) begin
      acc_d = base - shifted;
    end else begin
      acc_d = base + shifted;
    end
  end

  assign acc_pos = !acc_d[AccW-1] && (acc_d != '0);
  assign capture = adv && op_q.valid && op_q.last;

  always_comb begin
    res_d.on_line      = job_q.between && acc_pos;
    res_d.nearer_goal  = near_q;
    res_d.far_from_hit = far_q;
    res_d.leave_found  = found_q ||
                         (job_q.between && acc_pos && near_q && far_q);
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      job_q <= fifo_data_i;
    end
    if (adv) begin
      prod_q <= prod_d;
      acc_q  <= acc_d;
    end
    if (capture) begin
      case (op_q.dest)
        DstTol:   tol2_q      <= acc_d[TolSqW-1:0];
        DstLen:   len2_q      <= acc_d[ProdW-1:0];
        DstCross: cross_raw_q <= acc_d[ProdW:0];
        DstFar:   far_q       <= acc_pos;
        DstNear:  near_q      <= acc_pos;
        default:  ;
      endcase
    end
    cross_q <= cross_raw_q[ProdW] ? ProdW'(-cross_raw_q) : ProdW'(cross_raw_q);
    if (done) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= StTol;
      op_q        <= '0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (start) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (adv) begin
        op_q <= op_d;
      end
      if (done) begin
        found_q     <= res_d.leave_found;
        res_valid_q <= 1'b1;
      end else if (res_pop_i && res_valid_q) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

FILE: design/leave_point_detector.sv
// ----------------------------------------------------------------------------
// Leave point detector
// Tests a robot position against the start-goal line and the hit point.
// ----------------------------------------------------------------------------
// Usage:
// Positions enter through a queue-style port: an item is taken at a clock
// edge with push high and full low. Results leave the same way: the oldest
// result sits on result_o while empty is low and is taken with pop.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i while
// the block is idle; unknown indexes are ignored.
// Each item steps through the back-end sequencer, which runs every
// product through a single shared multiplier into one accumulator. A
// two-entry work queue lets the front take new items while the sequencer
// works on an earlier one.
// When the receiver stalls, the finished result is held and the sequencer
// waits on its last step; the queue then fills and full rises.
// Reset empties both queues, clears the sticky found flag and loads the
// default tolerance and minimum leave distance.
// ----------------------------------------------------------------------------
`default_nettype none

module leave_point_detector import lpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               push,
  output logic               full,
  input  item_t              in_item_i,
  output logic               empty,
  input  logic               pop,
  output result_t            result_o
);

  cfg_t  cfg;
  logic  fifo_push;
  logic  fifo_full;
  work_t fifo_wdata;
  logic  fifo_pop;
  logic  fifo_valid;
  work_t fifo_rdata;
  logic  res_valid;

  lpd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lpd_front u_front (
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cfg_i       (cfg),
    .fifo_full_i (fifo_full),
    .fifo_push_o (fifo_push),
    .fifo_data_o (fifo_wdata)
  );

  lpd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (fifo_wdata),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .valid_o (fifo_valid),
    .data_o  (fifo_rdata)
  );

  lpd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .fifo_valid_i (fifo_valid),
    .fifo_data_i  (fifo_rdata),
    .fifo_pop_o   (fifo_pop),
    .res_valid_o  (res_valid),
    .res_o        (result_o),
    .res_pop_i    (pop)
  );

  assign empty = !res_valid;

endmodule

`default_nettype wire

FILE: design/lpd_checker.sv
// ----------------------------------------------------------------------------
// Leave point detector port checker
// Watches item bookkeeping and the sticky found flag at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none

module lpd_checker import lpd_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    push,
  input logic    full,
  input logic    empty,
  input logic    pop,
  input result_t result_o
);

  logic [2:0] outstanding_q;
  logic       seen_found_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
      seen_found_q  <= 1'b0;
    end else begin
      if (in_acc && !out_acc) begin
        outstanding_q <= outstanding_q + 1'b1;
      end else if (out_acc && !in_acc) begin
        outstanding_q <= outstanding_q - 1'b1;
      end
      if (out_acc && result_o.leave_found) begin
        seen_found_q <= 1'b1;
      end
    end
  end

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result queue not empty during reset");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (outstanding_q != 3'd0))
    else $error("result shown without an accepted item");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q <= 3'd4)
    else $error("more items in flight than the block can hold");

  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && seen_found_q) |-> result_o.leave_found)
    else $error("found flag dropped after being set");

  a_found_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.on_line && result_o.nearer_goal && result_o.far_from_hit)
      |-> result_o.leave_found)
    else $error("all tests held but found flag is clear");

endmodule

bind leave_point_detector lpd_checker u_lpd_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .result_o (result_o)
);

`default_nettype wire

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// Leave point detector testbench
// Drives positions and hit points through the request port under several
// start, goal, tolerance and distance settings, and predicts the three leave
// tests and the sticky found flag with exact squared arithmetic. Every
// result is checked in order against the prediction. Both sides of the
// handshake idle at random, each alone in some phases, both in others.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import lpd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles = 30;
  localparam int ItemsPerPhase = 119;
  localparam int RandomPhases = 8;
  localparam int MaxReports = 100;
  localparam logic [CfgIdxW-1:0] IdxSpareLo = CfgIdxW'(RegMinLeave + 1);
  localparam logic [CfgIdxW-1:0] IdxSpareHi = '1;

  class leave_scoreboard;
    logic signed [CoordW-1:0] start_x, start_y, goal_x, goal_y;
    logic [DistW-1:0] tolerance, min_leave;
    bit found;
    result_t pending[$];
    int errors, checked, line_hits, near_hits, far_hits, found_hits;

    function new();
      start_x = '0;
      start_y = '0;
      goal_x = '0;
      goal_y = '0;
      tolerance = TolReset;
      min_leave = MinReset;
      found = 1'b0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        RegStartX: start_x = data[CoordW-1:0];
        RegStartY: start_y = data[CoordW-1:0];
        RegGoalX: goal_x = data[CoordW-1:0];
        RegGoalY: goal_y = data[CoordW-1:0];
        RegTolerance: tolerance = data[DistW-1:0];
        RegMinLeave: min_leave = data[DistW-1:0];
        default: ;
      endcase
    endfunction

    function longint dist_sq(longint ax, longint ay, longint bx, longint by);
      return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
    endfunction

    function result_t leave_verdict(item_t it);
      longint rx, ry, hx, hy, sx, sy, gx, gy, dx, dy, cross_p, mag, tol, mn;
      logic [127:0] cross_sq, bound;
      result_t r;
      rx = it.robot_x;
      ry = it.robot_y;
      hx = it.hit_x;
      hy = it.hit_y;
      sx = start_x;
      sy = start_y;
      gx = goal_x;
      gy = goal_y;
      tol = tolerance;
      mn = min_leave;
      dx = gx - sx;
      dy = gy - sy;
      cross_p = dy * (rx - sx) - dx * (ry - sy);
      mag = (cross_p < 0) ? -cross_p : cross_p;
      cross_sq = 128'(mag) * 128'(mag);
      bound = 128'(tol * tol) * 128'(dx * dx + dy * dy);
      r = '0;
      if (cross_sq < bound) begin
        if (sx < gx) begin
          r.on_line = rx > sx && rx < gx;
        end else if (sx > gx) begin
          r.on_line = rx < sx && rx > gx;
        end else if (sy < gy) begin
          r.on_line = ry > sy && ry < gy;
        end else begin
          r.on_line = ry < sy && ry > gy;
        end
      end
      r.nearer_goal = dist_sq(rx, ry, gx, gy) < dist_sq(hx, hy, gx, gy);
      r.far_from_hit = dist_sq(rx, ry, hx, hy) > mn * mn;
      if (r.on_line && r.nearer_goal && r.far_from_hit) begin
        found = 1'b1;
      end
      r.leave_found = found;
      return r;
    endfunction

    function void note_request(item_t it);
      pending.push_back(leave_verdict(it));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: unexpected result, expected none, got %b", $time, got);
        end
        return;
      end
      want = pending.pop_front();
      checked++;
      line_hits += got.on_line;
      near_hits += got.nearer_goal;
      far_hits += got.far_from_hit;
      found_hits += got.leave_found;
      if (got !== want) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("%0t: mismatch, expected on_line=%b nearer=%b far=%b found=%b, %s",
                   $time, want.on_line, want.nearer_goal, want.far_from_hit,
                   want.leave_found,
                   $sformatf("got on_line=%b nearer=%b far=%b found=%b", got.on_line,
                             got.nearer_goal, got.far_from_hit, got.leave_found));
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;
  logic push;
  logic full;
  item_t in_item_i;
  logic empty;
  logic pop;
  result_t result_o;

  leave_scoreboard sb;
  int sender_idle_pct;
  int receiver_stall_pct;
  int settings_count;
  int positions_sent;

  leave_point_detector i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .push      (push),
    .full      (full),
    .in_item_i (in_item_i),
    .empty     (empty),
    .pop       (pop),
    .result_o  (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL leave_point_detector");
    $finish;
  end

  function automatic logic signed [CoordW-1:0] clamp_coord(longint v);
    if (v > 32767) begin
      return 16'sh7fff;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return v[CoordW-1:0];
  endfunction

  function automatic item_t pos(int rx, int ry, int hx, int hy);
    item_t it;
    it.robot_x = rx[CoordW-1:0];
    it.robot_y = ry[CoordW-1:0];
    it.hit_x = hx[CoordW-1:0];
    it.hit_y = hy[CoordW-1:0];
    return it;
  endfunction

  function automatic longint jitter(longint span);
    return longint'($urandom_range(32'(2 * span))) - span;
  endfunction

  function automatic item_t random_position();
    longint sx, sy, dx, dy, t, th, tol, mn, ox;
    int kind;
    item_t it;
    sx = sb.start_x;
    sy = sb.start_y;
    dx = longint'(sb.goal_x) - sx;
    dy = longint'(sb.goal_y) - sy;
    tol = sb.tolerance;
    mn = sb.min_leave;
    kind = $urandom_range(9);
    if (kind < 6) begin
      t = $urandom_range(1024);
      th = $urandom_range(32'(t));
      it.robot_x = clamp_coord(sx + dx * t / 1024 + jitter(tol + 1));
      it.robot_y = clamp_coord(sy + dy * t / 1024 + jitter(tol + 1));
      it.hit_x = clamp_coord(sx + dx * th / 1024 + jitter(2 * mn + 1));
      it.hit_y = clamp_coord(sy + dy * th / 1024 + jitter(2 * mn + 1));
    end else if (kind < 8) begin
      it.hit_x = CoordW'($urandom);
      it.hit_y = CoordW'($urandom);
      ox = $urandom_range(32'(mn + 2));
      if ($urandom_range(1)) begin
        ox = -ox;
      end
      if ($urandom_range(1)) begin
        it.robot_x = clamp_coord(longint'(it.hit_x) + ox);
        it.robot_y = it.hit_y;
      end else begin
        it.robot_x = it.hit_x;
        it.robot_y = clamp_coord(longint'(it.hit_y) + ox);
      end
    end else begin
      it = {$urandom, $urandom};
    end
    return it;
  endfunction

  task automatic push_item(item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (full) begin
      @(posedge clk_i);
    end
    sb.note_request(it);
    positions_sent++;
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (sb.pending.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_settings(logic [CfgW-1:0] sx, logic [CfgW-1:0] sy,
                                logic [CfgW-1:0] gx, logic [CfgW-1:0] gy,
                                logic [CfgW-1:0] tol, logic [CfgW-1:0] mn);
    wait_drained();
    write_reg(RegStartX, sx);
    write_reg(RegStartY, sy);
    write_reg(RegGoalX, gx);
    write_reg(RegGoalY, gy);
    write_reg(RegTolerance, tol);
    write_reg(RegMinLeave, mn);
    write_reg(settings_count[0] ? IdxSpareHi : IdxSpareLo, CfgW'($urandom));
    cfg_we_i <= 1'b0;
    settings_count++;
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(2))
      0: return -32768;
      1: return 32767;
      default: return 0;
    endcase
  endfunction

  task automatic random_settings(int style);
    int sx, sy, gx, gy, tol, mn;
    sx = int'($urandom_range(8192)) - 4096;
    sy = int'($urandom_range(8192)) - 4096;
    gx = int'($urandom_range(8192)) - 4096;
    gy = int'($urandom_range(8192)) - 4096;
    tol = $urandom_range(1024);
    mn = $urandom_range(4096);
    case (style)
      1: begin
        sx = $urandom;
        sy = $urandom;
        gx = $urandom;
        gy = $urandom;
        tol = $urandom;
        mn = $urandom;
      end
      2: begin
        sx = pick_extreme();
        sy = pick_extreme();
        gx = pick_extreme();
        gy = pick_extreme();
        tol = $urandom_range(1) ? 65535 : 0;
        mn = $urandom_range(1) ? 65535 : 0;
      end
      3: gx = sx;
      4: begin
        gx = sx;
        gy = sy;
      end
      default: ;
    endcase
    apply_settings(CfgW'(sx), CfgW'(sy), CfgW'(gx), CfgW'(gy), CfgW'(tol), CfgW'(mn));
  endtask

  initial begin
    int styles[RandomPhases] = '{0, 3, 1, 0, 2, 0, 4, 0};
    sb = new();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= RegStartX;
    cfg_data_i <= '0;
    push <= 1'b0;
    in_item_i <= '0;
    pop <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    fork
      forever begin
        pop <= ($urandom_range(99) >= receiver_stall_pct);
        @(posedge clk_i);
        if (pop && !empty) begin
          sb.check_result(result_o);
        end
      end
    join_none

    // With start and goal both at the origin the line is degenerate.
    push_item(pos(0, 0, 0, 0));
    push_item(pos(32767, 32767, -32768, -32768));
    push_item(pos(-32768, -32768, 32767, 32767));
    push_item(pos(-32768, 32767, 32767, -32768));

    apply_settings(-2048, 0, 2048, 0, 128, 512);
    push_item(pos(0, 100, 0, 0));
    push_item(pos(0, 0, -300, 0));
    push_item(pos(-2048, 0, -3000, 0));
    push_item(pos(2048, 0, -3000, 0));
    push_item(pos(0, 128, -2048, 0));
    push_item(pos(0, 0, -512, 0));
    push_item(pos(0, -127, -1000, 0));

    apply_settings(100, -1000, 100, 1000, 256, 0);
    push_item(pos(100, 0, 100, -1000));
    push_item(pos(100, 1000, 100, -1000));
    push_item(pos(356, 0, 0, 0));

    apply_settings(0, 1000, 0, -1000, 128, 512);
    push_item(pos(5, 0, 0, 1000));
    push_item(pos(0, -1000, 0, 0));

    apply_settings(3000, 500, -3000, -500, 64, 1024);
    push_item(pos(0, 0, 3000, 500));
    push_item(pos(-3000, -500, 0, 0));

    apply_settings(-32768, -32768, 32767, 32767, 65535, 65535);
    push_item(pos(0, 0, -32768, -32768));
    push_item(pos(32767, -32768, -32768, 32767));

    apply_settings(32767, 32767, -32768, -32768, 0, 0);
    push_item(pos(0, 0, 0, 0));
    push_item(pos(1, 1, 0, 0));

    for (int phase = 0; phase < RandomPhases; phase++) begin
      random_settings(styles[phase]);
      sender_idle_pct = (phase % 4 == 1 || phase % 4 == 2) ? 84 * (phase % 4 == 1) : 0;
      receiver_stall_pct = (phase % 4 == 2) ? 84 : 0;
      if (phase % 4 == 3) begin
        sender_idle_pct = 16;
        receiver_stall_pct = 16;
      end
      for (int n = 0; n < ItemsPerPhase; n++) begin
        push_item(random_position());
      end
    end

    wait_drained();
    $display("Sent %0d positions under %0d settings, checked %0d results.",
             positions_sent, settings_count, sb.checked);
    $display("Results with on_line %0d, nearer_goal %0d, far_from_hit %0d, found %0d.",
             sb.line_hits, sb.near_hits, sb.far_hits, sb.found_hits);
    if (sb.errors == 0) begin
      $display("PASS leave_point_detector");
    end else begin
      $display("FAIL leave_point_detector");
    end
    $finish;
  end

endmodule

`default_nettype wire
